// File: rtl/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned CandW  = 32;
  localparam int unsigned ShiftW = 6;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } ctc_gcd_stat_t;

endpackage

// File: rtl/ctc_gcd_core.sv
module ctc_gcd_core
  import ctc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DataW-1:0]    op_a_i,
  input  logic [DataW-1:0]    op_b_i,
  input  logic                ack_i,
  output ctc_gcd_stat_t       stat_o,
  output logic [DataW-1:0]    gcd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StScale,
    StDone
  } state_e;

  state_e            state_q;
  logic [DataW-1:0]  u_q;
  logic [DataW-1:0]  v_q;
  logic [DataW-1:0]  res_q;
  logic [ShiftW-1:0] k_q;
  logic [DataW:0]    diff;

  // the one shared subtractor, its borrow is the compare
  assign diff = {1'b0, u_q} - {1'b0, v_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      u_q     <= '0;
      v_q     <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            u_q     <= op_a_i;
            v_q     <= op_b_i;
            k_q     <= '0;
            state_q <= StReduce;
          end
        end
        StReduce: begin
          priority if (u_q == '0) begin
            res_q   <= v_q;
            state_q <= StScale;
          end else if (v_q == '0) begin
            res_q   <= u_q;
            state_q <= StScale;
          end else if (!u_q[0] && !v_q[0]) begin
            // common factor of two, restored in the scale phase
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + ShiftW'(1);
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (diff[DataW]) begin
            // keep u as the larger odd value
            u_q <= v_q;
            v_q <= u_q;
          end else begin
            u_q <= diff[DataW-1:0] >> 1;
          end
        end
        StScale: begin
          if (k_q == '0) begin
            state_q <= StDone;
          end else begin
            res_q <= res_q << 1;
            k_q   <= k_q - ShiftW'(1);
          end
        end
        StDone: begin
          if (ack_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = (state_q == StDone);
  assign gcd_o       = res_q;

endmodule

// File: rtl/coprime_test_counter_top.sv
// an item is taken into the core, reduced by the binary gcd loop, scaled back by each
// common factor of two and then loaded into the output register; the time is data dependent
// throughput: one item at a time, set by the serial binary gcd loop on one subtractor
// a finished result waits in the output register while the next item is taken
// reset: asynchronous active low, reference number returns to 1, count to 0
module coprime_test_counter_top
  import ctc_pkg::*;
#(
  parameter int CANDIDATE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CandW-1:0]   candidate_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   divisor_o,
  output logic               is_coprime_o,
  output logic [CountW-1:0]  coprime_count_o,
  output logic               end_of_run_o
);

  localparam int UseBits = (CANDIDATE_BITS < CandW) ? CANDIDATE_BITS : CandW;
  localparam logic [CandW-1:0] CandMask = CandW'((64'(1) << UseBits) - 64'(1));

  logic [DataW-1:0]  ref_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              busy_q;
  logic              last_q;
  logic              out_valid_q;
  logic              in_xfer;
  logic              load;
  logic              coprime;
  logic [DataW-1:0]  gcd;
  ctc_gcd_stat_t     gcd_stat;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load       = gcd_stat.done && (!out_valid_q || out_ready_i);

  ctc_gcd_core u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .op_a_i  (DataW'(candidate_i & CandMask)),
    .op_b_i  (ref_q),
    .ack_i   (load),
    .stat_o  (gcd_stat),
    .gcd_o   (gcd)
  );

  assign coprime = (gcd == DataW'(1));
  assign count_d = (coprime && count_q != CountMax) ? count_q + CountW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= DataW'(1);
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ref_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        busy_q <= 1'b1;
        last_q <= last_item_i;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        count_q     <= last_q ? '0 : count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded when the core hands over
  always_ff @(posedge clk_i) begin
    if (load) begin
      divisor_o       <= gcd;
      is_coprime_o    <= coprime;
      coprime_count_o <= count_d;
      end_of_run_o    <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_in_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_stat.done |-> busy_q)
    else $error("gcd result without an item in flight");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !gcd_stat.busy)
    else $error("item transfer while gcd core busy");

  a_count_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && last_q |=> count_q == '0)
    else $error("count not cleared after end of run");

  a_coprime_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(load) && out_valid_o |-> (is_coprime_o == (divisor_o == DataW'(1))))
    else $error("coprime flag disagrees with divisor");

endmodule

// File: verif/coprime_test_counter_top_test.sv
`timescale 1ns / 1ps

import ctc_pkg::*;

class CoprimeScoreboard #(int CandBits = 32);

  typedef struct {
    logic [DataW-1:0]  divisor;
    logic              is_coprime;
    logic [CountW-1:0] coprime_count;
    logic              end_of_run;
  } gcd_result_t;

  logic [DataW-1:0]  reference_number;
  logic [CountW-1:0] coprime_tally;
  gcd_result_t       gcd_results_q[$];
  int unsigned       errors;

  function new();
    reference_number = 64'd1;
    coprime_tally    = '0;
    errors           = 0;
  endfunction

  function void set_reference(input logic [DataW-1:0] value);
    reference_number = value;
  endfunction

  function logic [DataW-1:0] euclid(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] rem;
    x = a;
    y = b;
    while (y != 0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    return x;
  endfunction

  function void note_input(input logic [CandW-1:0] candidate, input logic last_item);
    logic [DataW-1:0] cand_mask;
    logic [DataW-1:0] cand;
    gcd_result_t      res;
    cand_mask = (CandBits >= 64) ? '1 : ((64'd1 << CandBits) - 64'd1);
    cand = {{(DataW-CandW){1'b0}}, candidate} & cand_mask;
    res.divisor    = euclid(cand, reference_number);
    res.is_coprime = (res.divisor == 64'd1);
    if (res.is_coprime && coprime_tally != CountMax) coprime_tally++;
    res.coprime_count = coprime_tally;
    res.end_of_run    = last_item;
    // count clears only after the last item's result is formed
    if (last_item) coprime_tally = '0;
    gcd_results_q.push_back(res);
  endfunction

  function void check_result(input logic [DataW-1:0] divisor, input logic is_coprime,
                             input logic [CountW-1:0] coprime_count, input logic end_of_run);
    gcd_result_t exp_res;
    if (gcd_results_q.size() == 0) begin
      $error("result transfer with nothing expected: divisor %0h", divisor);
      errors++;
      return;
    end
    exp_res = gcd_results_q.pop_front();
    if (divisor !== exp_res.divisor) begin
      $error("divisor: expected %0h, actual %0h", exp_res.divisor, divisor);
      errors++;
    end
    if (is_coprime !== exp_res.is_coprime) begin
      $error("is_coprime: expected %0b, actual %0b", exp_res.is_coprime, is_coprime);
      errors++;
    end
    if (coprime_count !== exp_res.coprime_count) begin
      $error("coprime_count: expected %0d, actual %0d", exp_res.coprime_count, coprime_count);
      errors++;
    end
    if (end_of_run !== exp_res.end_of_run) begin
      $error("end_of_run: expected %0b, actual %0b", exp_res.end_of_run, end_of_run);
      errors++;
    end
  endfunction

  function int unsigned pending_count();
    return gcd_results_q.size();
  endfunction

endclass

module coprime_test_counter_top_test;

  localparam int          CandBits   = 32;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SmallPrimes [10] = '{2, 3, 5, 7, 11, 13, 17, 31, 257, 65537};
  localparam int unsigned Factors [12] = '{2, 3, 4, 5, 6, 7, 9, 16, 17, 255, 641, 65537};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CandW-1:0]   candidate_i;
  logic               last_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DataW-1:0]   divisor_o;
  logic               is_coprime_o;
  logic [CountW-1:0]  coprime_count_o;
  logic               end_of_run_o;

  CoprimeScoreboard #(CandBits) gcd_sb;

  bit          gaps_on;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned stall_cycles;

  coprime_test_counter_top #(
    .CANDIDATE_BITS(CandBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .candidate_i    (candidate_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .divisor_o      (divisor_o),
    .is_coprime_o   (is_coprime_o),
    .coprime_count_o(coprime_count_o),
    .end_of_run_o   (end_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycles without any transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: check each transfer, then pick next ready
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        gcd_sb.check_result(divisor_o, is_coprime_o, coprime_count_o, end_of_run_o);
      end
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !gaps_on || ($urandom_range(99) >= 19);
      end
    end
  end

  task automatic send_candidate(input logic [CandW-1:0] cand, input logic last);
    while (gaps_on && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= cand;
    last_item_i <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    gcd_sb.note_input(cand, last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (gcd_sb.pending_count() != 0);
  endtask

  task automatic set_reference(input logic [DataW-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gcd_sb.set_reference(value);
  endtask

  function automatic logic [DataW-1:0] pick_reference();
    logic [DataW-1:0] refnum;
    logic [DataW-1:0] p;
    case ($urandom_range(3))
      0: refnum = {$urandom(), $urandom()};
      1: begin
        // smooth number, lots of shared small factors
        refnum = 64'd1;
        repeat ($urandom_range(1, 14)) begin
          p = SmallPrimes[$urandom_range(9)];
          if (refnum <= 64'hFFFF_FFFF_FFFF_FFFF / p) refnum = refnum * p;
        end
      end
      2: refnum = {32'h0, $urandom()} << $urandom_range(32);
      default: refnum = {32'h0, $urandom()};
    endcase
    if (refnum == 0) refnum = 64'd1;
    return refnum;
  endfunction

  function automatic logic [CandW-1:0] pick_candidate(input logic [DataW-1:0] refnum);
    logic [CandW-1:0] cand;
    case ($urandom_range(9))
      0, 1, 2, 3: cand = $urandom();
      4, 5, 6:    cand = $urandom_range(1, 20'hFFFFF) * Factors[$urandom_range(11)];
      7:          cand = $urandom_range(16);
      8:          cand = refnum[CandW-1:0];
      default:    cand = CandW'(refnum >> $urandom_range(32));
    endcase
    return cand;
  endfunction

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    candidate_i  = '0;
    last_item_i  = 1'b0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    stall_cycles = 0;
    gcd_sb       = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reference still at its reset value of one
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'h0000_0001, 1'b0);
    send_candidate(32'hFFFF_FFFF, 1'b0);
    send_candidate(32'h8000_0000, 1'b1);

    set_reference(64'hFFFF_FFFF_FFFF_FFFF);
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'hFFFF_FFFF, 1'b0);
    send_candidate(32'h0001_0001, 1'b1);
    send_candidate(32'h0000_0002, 1'b1);

    set_reference(64'h8000_0000_0000_0000);
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'h8000_0000, 1'b0);
    send_candidate(32'h0000_0006, 1'b0);
    send_candidate(32'h0000_0007, 1'b1);

    // largest 64-bit prime
    set_reference(64'hFFFF_FFFF_FFFF_FFC5);
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'h0000_0001, 1'b0);
    send_candidate(32'hFFFF_FFFF, 1'b0);
    send_candidate(32'hFFFF_FFC5, 1'b1);

    // product of the first fifteen primes
    set_reference(64'd614889782588491410);
    send_candidate(32'h0000_0000, 1'b0);
    send_candidate(32'd30030, 1'b0);
    send_candidate(32'd47, 1'b0);
    send_candidate(32'd3127, 1'b1);

    set_reference(64'd1);
    send_candidate(32'h0000_0000, 1'b1);
    send_candidate(32'h1234_5678, 1'b0);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       set_reference(64'hFFFF_FFFF_FFFF_FFFF);
        1:       set_reference(64'd1);
        default: set_reference(pick_reference());
      endcase
      gaps_on = (phase != 4);
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < 50; n++) begin
        if (phase == 6 && n == 25) wait_drained();
        send_candidate(pick_candidate(gcd_sb.reference_number), $urandom_range(11) == 0);
      end
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (gcd_sb.errors == 0 && gcd_sb.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
